// ===== sv/multi_format_yuv_to_rgbx_macros.svh =====
// Assertion helpers shared by the converter RTL.
`ifndef MULTI_FORMAT_YUV_TO_RGBX_MACROS_SVH
`define MULTI_FORMAT_YUV_TO_RGBX_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define MFY_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define MFY_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/mfy2rgb_pkg.sv =====
package mfy2rgb_pkg;

    typedef enum logic [1:0] {
        FMT_NV21   = 2'd0,
        FMT_YUYV   = 2'd1,
        FMT_UYVY   = 2'd2,
        FMT_RGB888 = 2'd3
    } t_src_fmt;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
        logic [7:0] byte5;
        logic       single_pixel;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red0;
        logic [7:0] green0;
        logic [7:0] blue0;
        logic [7:0] red1;
        logic [7:0] green1;
        logic [7:0] blue1;
        logic       second_valid;
    } t_out_item;

    // Limited-range luma gain: 0x0101 * 18997 folded into one constant.
    localparam logic [30:0] NV_YL_K = 31'd4882229;
    localparam logic [14:0] NV_VR_K = 15'd102;
    localparam logic [14:0] NV_VG_K = 15'd52;
    localparam logic [14:0] NV_UG_K = 15'd25;

    // Per-channel biases: coefficient * 128 plus the luma offset of -1160.
    localparam logic signed [17:0] NV_BR = -18'sd14216;
    localparam logic signed [17:0] NV_BG = 18'sd8696;
    localparam logic signed [17:0] NV_BB = -18'sd17544;

    localparam logic signed [24:0] Q14_VR = 25'sd22987;
    localparam logic signed [24:0] Q14_UG = -25'sd5636;
    localparam logic signed [24:0] Q14_VG = -25'sd11698;
    localparam logic signed [24:0] Q14_UB = 25'sd29049;

endpackage

// ===== sv/multi_format_yuv_to_rgbx.sv =====
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready   o_out_data (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_data (source format)
//
// Three register stages: multiply, sum and shift, clamp into the output register.
// One request per cycle in steady state while the output is not stalled.
// Each stage moves on when it is empty or the stage after it moves, so bubbles close up
// and a stalled output still lets the earlier stages fill.
// Synchronous active-low reset clears the stage valid bits and the format (NV21).
`include "multi_format_yuv_to_rgbx_macros.svh"

module multi_format_yuv_to_rgbx
    import mfy2rgb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    typedef struct packed {
        t_in_item           raw;
        logic [7:0]         y0;
        logic [7:0]         y1;
        logic [14:0]        yl0;
        logic [14:0]        yl1;
        logic [14:0]        cr;
        logic [14:0]        cg;
        logic [14:0]        cb;
        logic signed [24:0] mr;
        logic signed [24:0] mgu;
        logic signed [24:0] mgv;
        logic signed [24:0] mb;
    } t_s1;

    typedef struct packed {
        logic signed [11:0] r0;
        logic signed [11:0] g0;
        logic signed [11:0] b0;
        logic signed [11:0] r1;
        logic signed [11:0] g1;
        logic signed [11:0] b1;
        logic               lone;
    } t_s2;

    t_src_fmt   r_fmt;
    logic [2:0] r_vld;
    logic [2:0] w_rdy;
    t_s1        r_s1, n_s1;
    t_s2        r_s2, n_s2;
    t_out_item  r_out, n_out;

    function automatic logic [7:0] clamp8(input logic signed [11:0] v);
        logic [7:0] res;
        if (v[11]) begin
            res = 8'd0;
        end else if (v[10:8] != 3'd0) begin
            res = 8'hff;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    assign w_rdy[2]    = !r_vld[2] || i_out_ready;
    assign w_rdy[1]    = !r_vld[1] || w_rdy[2];
    assign w_rdy[0]    = !r_vld[0] || w_rdy[1];
    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[2];
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_NV21;
            r_vld <= 3'b000;
        end else begin
            if (i_cfg_valid) begin
                r_fmt <= t_src_fmt'(i_cfg_data);
            end
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_in_valid) begin
            r_s1 <= n_s1;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_s2 <= n_s2;
        end
        if (w_rdy[2] && r_vld[1]) begin
            r_out <= n_out;
        end
    end

    // Stage 1: pick luma and chroma bytes for the format, then the constant products.
    always_comb begin
        logic [7:0]         y0, y1, u, v;
        logic signed [8:0]  du, dv;
        logic signed [24:0] du_x, dv_x;
        logic [30:0]        p0, p1;
        y0 = i_in_data.byte0;
        y1 = i_in_data.byte1;
        u  = i_in_data.byte3;
        v  = i_in_data.byte2;
        unique case (r_fmt)
            FMT_YUYV: begin
                y0 = i_in_data.byte0;
                y1 = i_in_data.byte2;
                u  = i_in_data.byte1;
                v  = i_in_data.byte3;
            end
            FMT_UYVY: begin
                y0 = i_in_data.byte1;
                y1 = i_in_data.byte3;
                u  = i_in_data.byte0;
                v  = i_in_data.byte2;
            end
            default: begin
                y0 = i_in_data.byte0;
                y1 = i_in_data.byte1;
                u  = i_in_data.byte3;
                v  = i_in_data.byte2;
            end
        endcase
        du   = $signed({1'b0, u}) - 9'sd128;
        dv   = $signed({1'b0, v}) - 9'sd128;
        du_x = {{16{du[8]}}, du};
        dv_x = {{16{dv[8]}}, dv};
        p0   = {23'd0, y0} * NV_YL_K;
        p1   = {23'd0, y1} * NV_YL_K;

        n_s1.raw = i_in_data;
        n_s1.y0  = y0;
        n_s1.y1  = y1;
        n_s1.yl0 = p0[30:16];
        n_s1.yl1 = p1[30:16];
        n_s1.cr  = {7'd0, v} * NV_VR_K;
        n_s1.cg  = {7'd0, v} * NV_VG_K + {7'd0, u} * NV_UG_K;
        n_s1.cb  = {u, 7'd0};
        n_s1.mr  = dv_x * Q14_VR;
        n_s1.mgu = du_x * Q14_UG;
        n_s1.mgv = dv_x * Q14_VG;
        n_s1.mb  = du_x * Q14_UB;
    end

    // Stage 2: for each channel, bias and floor shift (NV21) or luma add (YUYV, UYVY); RGB888 passes through.
    always_comb begin
        logic signed [17:0] yl0, yl1, cr, cg, cb;
        logic signed [17:0] nr0, ng0, nb0, nr1, ng1, nb1;
        logic signed [17:0] sr0, sg0, sb0, sr1, sg1, sb1;
        logic signed [24:0] mr, mb, mg, qr, qg, qb;
        logic signed [11:0] ys0, ys1, tr, tg, tb;
        yl0 = {3'b000, r_s1.yl0};
        yl1 = {3'b000, r_s1.yl1};
        cr  = {3'b000, r_s1.cr};
        cg  = {3'b000, r_s1.cg};
        cb  = {3'b000, r_s1.cb};
        nr0 = yl0 + cr + NV_BR;
        ng0 = yl0 - cg + NV_BG;
        nb0 = yl0 + cb + NV_BB;
        nr1 = yl1 + cr + NV_BR;
        ng1 = yl1 - cg + NV_BG;
        nb1 = yl1 + cb + NV_BB;
        sr0 = nr0 >>> 6;
        sg0 = ng0 >>> 6;
        sb0 = nb0 >>> 6;
        sr1 = nr1 >>> 6;
        sg1 = ng1 >>> 6;
        sb1 = nb1 >>> 6;

        mr  = r_s1.mr;
        mb  = r_s1.mb;
        mg  = r_s1.mgu + r_s1.mgv;
        qr  = mr >>> 14;
        qg  = mg >>> 14;
        qb  = mb >>> 14;
        tr  = qr[11:0];
        tg  = qg[11:0];
        tb  = qb[11:0];
        ys0 = {4'b0000, r_s1.y0};
        ys1 = {4'b0000, r_s1.y1};

        n_s2.lone = r_s1.raw.single_pixel;
        unique case (r_fmt)
            FMT_NV21: begin
                n_s2.r0 = sr0[11:0];
                n_s2.g0 = sg0[11:0];
                n_s2.b0 = sb0[11:0];
                n_s2.r1 = sr1[11:0];
                n_s2.g1 = sg1[11:0];
                n_s2.b1 = sb1[11:0];
            end
            FMT_YUYV, FMT_UYVY: begin
                n_s2.r0 = ys0 + tr;
                n_s2.g0 = ys0 + tg;
                n_s2.b0 = ys0 + tb;
                n_s2.r1 = ys1 + tr;
                n_s2.g1 = ys1 + tg;
                n_s2.b1 = ys1 + tb;
            end
            default: begin
                n_s2.r0 = {4'b0000, r_s1.raw.byte0};
                n_s2.g0 = {4'b0000, r_s1.raw.byte1};
                n_s2.b0 = {4'b0000, r_s1.raw.byte2};
                n_s2.r1 = {4'b0000, r_s1.raw.byte3};
                n_s2.g1 = {4'b0000, r_s1.raw.byte4};
                n_s2.b1 = {4'b0000, r_s1.raw.byte5};
            end
        endcase
    end

    // Stage 3: clamp, and blank the second pixel of a lone request.
    always_comb begin
        n_out.red0         = clamp8(r_s2.r0);
        n_out.green0       = clamp8(r_s2.g0);
        n_out.blue0        = clamp8(r_s2.b0);
        n_out.red1         = r_s2.lone ? 8'd0 : clamp8(r_s2.r1);
        n_out.green1       = r_s2.lone ? 8'd0 : clamp8(r_s2.g1);
        n_out.blue1        = r_s2.lone ? 8'd0 : clamp8(r_s2.b1);
        n_out.second_valid = !r_s2.lone;
    end

    `MFY_ASSERT_NEXT(a_s1_moves_on, r_vld[0] && !r_vld[1], r_vld[1])
    `MFY_ASSERT_NEXT(a_s1_held, r_vld[0] && !w_rdy[1], r_vld[0] && $stable(r_s1))
    `MFY_ASSERT_NOW(a_empty_ready, r_vld == 3'b000, o_in_ready)
    `MFY_ASSERT_NOW(a_lone_blank, o_out_valid && !o_out_data.second_valid, o_out_data.red1 == 8'd0 && o_out_data.green1 == 8'd0 && o_out_data.blue1 == 8'd0)

endmodule
